FILE: rtl/mini_printf_formatter_assert.svh
// ----------------------------------------------------------------------------
// Mini printf formatter: assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef MINI_PRINTF_FORMATTER_ASSERT_SVH
`define MINI_PRINTF_FORMATTER_ASSERT_SVH

// Same-cycle implication, switched off while reset is held.
`define MPF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mini_printf_formatter: implication check failed");

// Next-cycle implication, switched off while reset is held.
`define MPF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mini_printf_formatter: next-cycle check failed");

// A condition that must never be seen outside reset.
`define MPF_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("mini_printf_formatter: forbidden condition seen");

`endif

FILE: rtl/mpf_pkg.sv
// ----------------------------------------------------------------------------
// Mini printf formatter package
// Widths, character codes, sequencer types and digit helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package mpf_pkg;

    localparam int MAX_LEN_DEF = 256;
    localparam int CNT_W       = 9;
    localparam int CHAR_W      = 8;
    localparam int ARG_W       = 32;
    localparam int BCD_DIGITS  = 10;
    localparam int BCD_W       = 4 * BCD_DIGITS;
    localparam int IDX_W       = 4;
    localparam int STEP_W      = $clog2(ARG_W);
    localparam int WCNT_W      = 6;

    localparam logic [CNT_W-1:0]  CAP_RESET  = CNT_W'(256);
    localparam logic [WCNT_W-1:0] WORD_LAST  = WCNT_W'(34);
    localparam logic [3:0]        GROUP_SEP  = 4'd8;

    localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
    localparam logic [CHAR_W-1:0] CH_PCT    = 8'h25;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_ONE    = 8'h31;
    localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
    localparam logic [CHAR_W-1:0] CH_HEX_UP = 8'h58;
    localparam logic [CHAR_W-1:0] CH_USCORE = 8'h5F;
    localparam logic [CHAR_W-1:0] CH_DEC    = 8'h64;
    localparam logic [CHAR_W-1:0] CH_WORD   = 8'h77;
    localparam logic [CHAR_W-1:0] CH_HEX_LO = 8'h78;

    // Element 0 is '0', element 15 is 'F'.
    localparam logic [15:0][CHAR_W-1:0] HEX_GLYPHS = "FEDCBA9876543210";

    typedef logic [BCD_DIGITS-1:0][3:0] t_digits;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_NUM,
        S_WORD,
        S_CHAR
    } t_state;

    typedef enum logic [1:0] {
        PH_TEXT,
        PH_PCT,
        PH_WIDTH
    } t_phase;

    typedef enum logic [3:0] {
        ACT_END,
        ACT_SKIP,
        ACT_WIDTH,
        ACT_DEC,
        ACT_HEX,
        ACT_WORD,
        ACT_BAD,
        ACT_PCT,
        ACT_TEXT
    } t_action;

    typedef struct packed {
        logic busy;
        logic done;
    } t_conv_status;

    function automatic logic [CHAR_W-1:0] glyph(input logic [3:0] nib);
        glyph = HEX_GLYPHS[nib];
    endfunction

    // Number of characters a conversion emits: significant digits, raised
    // to the pad width where that is larger.
    function automatic logic [IDX_W-1:0] emit_count(input t_digits digs,
                                                    input logic [3:0] pad);
        logic [IDX_W-1:0] ndig;
        ndig = '0;
        for (int k = 0; k < BCD_DIGITS; k++) begin
            if (digs[k] != 4'd0) begin
                ndig = IDX_W'(k + 1);
            end
        end
        emit_count = (ndig > pad) ? ndig : pad;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/mpf_if.sv
// ----------------------------------------------------------------------------
// Mini printf formatter channels
// Valid/ready interfaces for configuration, format input and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface mpf_cfg_if;
    import mpf_pkg::*;
    logic               valid;
    logic               ready;
    logic [CNT_W-1:0]   capacity;
    modport source (output valid, output capacity, input ready);
    modport sink   (input valid, input capacity, output ready);
endinterface

interface mpf_in_if;
    import mpf_pkg::*;
    logic               valid;
    logic               ready;
    logic [CHAR_W-1:0]  fmt_char;
    logic [ARG_W-1:0]   arg_value;
    modport source (output valid, output fmt_char, output arg_value, input ready);
    modport sink   (input valid, input fmt_char, input arg_value, output ready);
endinterface

interface mpf_out_if;
    import mpf_pkg::*;
    logic               valid;
    logic               ready;
    logic [CHAR_W-1:0]  out_char;
    logic               last;
    logic [CNT_W-1:0]   total_length;
    logic               bad_specifier;
    modport source (output valid, output out_char, output last,
                    output total_length, output bad_specifier, input ready);
    modport sink   (input valid, input out_char, input last,
                    input total_length, input bad_specifier, output ready);
endinterface

`default_nettype wire

FILE: rtl/mpf_bcd_unit.sv
// ----------------------------------------------------------------------------
// Mini printf formatter: binary to BCD unit
// Shift-and-add-three converter, one bit of the argument per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mpf_bcd_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [mpf_pkg::ARG_W-1:0]    i_value,
    output mpf_pkg::t_conv_status        o_status,
    output mpf_pkg::t_digits             o_digits
);
    import mpf_pkg::*;

    logic [ARG_W-1:0]  r_bin, n_bin;
    t_digits           r_bcd, n_bcd;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic              r_busy, n_busy;
    logic              r_done, n_done;
    t_digits           w_adj;
    logic [BCD_W-1:0]  w_adj_flat;

    // Every BCD digit of five or more is corrected before the shift.
    always_comb begin
        for (int k = 0; k < BCD_DIGITS; k++) begin
            w_adj[k] = (r_bcd[k] >= 4'd5) ? (r_bcd[k] + 4'd3) : r_bcd[k];
        end
    end

    assign w_adj_flat = w_adj;

    always_comb begin
        n_bin  = r_bin;
        n_bcd  = r_bcd;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_bin  = i_value;
            n_bcd  = '0;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_bcd = t_digits'({w_adj_flat[BCD_W-2:0], r_bin[ARG_W-1]});
            n_bin = {r_bin[ARG_W-2:0], 1'b0};
            n_cnt = r_cnt + STEP_W'(1);
            if (r_cnt == STEP_W'(ARG_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin <= n_bin;
        r_bcd <= n_bcd;
    end

    assign o_status = '{busy: r_busy, done: r_done};
    assign o_digits = r_bcd;

endmodule

`default_nettype wire

FILE: rtl/mini_printf_formatter.sv
// ----------------------------------------------------------------------------
// Mini printf formatter
// Streams a format string one character per transaction and emits the
// formatted text one character per result transaction.
// ----------------------------------------------------------------------------
// Sequencing: plain text and the end character give their result the cycle
//   after acceptance, as do %x and %w (35 results, fewer if the buffer fills);
//   %d first waits while the shift-and-add-three unit takes its 32 steps.
// Flow: results go out one per cycle while the sink is ready; a new item is
//   taken only after the last one is through, and the input
//   is not ready meanwhile.
// Reset (synchronous, active low): capacity returns to 256, the string state
//   is cleared and the sequencer idles; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module mini_printf_formatter #(
    parameter int MAX_LEN = mpf_pkg::MAX_LEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mpf_cfg_if.sink     i_cfg,
    mpf_in_if.sink      i_fmt,
    mpf_out_if.source   o_res
);
    import mpf_pkg::*;

    // The capacity register is nine bits wide, so a larger MAX_LEN never
    // limits anything.
    localparam int               CLAMP_INT = (MAX_LEN > 511) ? 511 : MAX_LEN;
    localparam logic [CNT_W-1:0] CAP_CLAMP = CNT_W'(CLAMP_INT);

    // Sequencer and string state.
    t_state              r_state, n_state;
    t_phase              r_phase, n_phase;
    logic [CNT_W-1:0]    r_capacity;
    logic [CNT_W-1:0]    r_written, n_written;
    logic [CNT_W-1:0]    r_total, n_total;
    logic [3:0]          r_pad, n_pad;
    logic                r_stopped, n_stopped;
    logic                r_error, n_error;
    logic                r_nul, n_nul;
    logic                r_bad, n_bad;

    // Emission payload.
    t_digits             r_digits, n_digits;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [ARG_W-1:0]    r_word, n_word;
    logic [3:0]          r_grp, n_grp;
    logic [WCNT_W-1:0]   r_wcnt, n_wcnt;
    logic [CHAR_W-1:0]   r_char, n_char;

    // Decode.
    logic                w_accept;
    logic                w_emit;
    logic [CHAR_W-1:0]   w_ch;
    logic [ARG_W-1:0]    w_arg;
    logic [CNT_W-1:0]    w_cap_eff;
    logic [CNT_W-1:0]    w_limit;
    logic [CNT_W-1:0]    w_written_inc;
    logic                w_blocked;
    logic                w_full;
    logic                w_last;
    t_action             w_action;
    logic [IDX_W-1:0]    w_hex_count;
    logic [IDX_W-1:0]    w_dec_count;
    logic                w_start;
    t_conv_status        w_conv;
    t_digits             w_bcd;

    mpf_bcd_unit u_bcd (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_value  (w_arg),
        .o_status (w_conv),
        .o_digits (w_bcd)
    );

    assign w_ch   = i_fmt.fmt_char;
    assign w_arg  = i_fmt.arg_value;
    assign w_accept = i_fmt.valid && i_fmt.ready;
    assign w_emit   = o_res.valid && o_res.ready;

    // Writable positions: capacity clamped to 1..MAX_LEN, less one for NUL.
    always_comb begin
        if (r_capacity == '0) begin
            w_cap_eff = CNT_W'(1);
        end else if (r_capacity > CAP_CLAMP) begin
            w_cap_eff = CAP_CLAMP;
        end else begin
            w_cap_eff = r_capacity;
        end
    end

    assign w_limit       = w_cap_eff - CNT_W'(1);
    assign w_written_inc = r_written + CNT_W'(1);
    assign w_blocked     = r_stopped || (r_written >= w_limit);
    // The character now on the port fills the buffer.
    assign w_full        = (w_written_inc >= w_limit);

    assign w_hex_count = emit_count(t_digits'({8'h00, w_arg}), r_pad);
    assign w_dec_count = emit_count(w_bcd, r_pad);

    // Classify the incoming character; order matters here.
    always_comb begin
        priority if (w_ch == CH_NUL) begin
            w_action = ACT_END;
        end else if (w_blocked) begin
            w_action = ACT_SKIP;
        end else if (r_phase == PH_PCT && w_ch >= CH_ZERO && w_ch <= CH_NINE) begin
            w_action = ACT_WIDTH;
        end else if (r_phase != PH_TEXT) begin
            if (w_ch == CH_DEC) begin
                w_action = ACT_DEC;
            end else if (w_ch == CH_HEX_LO || w_ch == CH_HEX_UP) begin
                w_action = ACT_HEX;
            end else if (w_ch == CH_WORD) begin
                w_action = ACT_WORD;
            end else begin
                w_action = ACT_BAD;
            end
        end else if (w_ch == CH_PCT) begin
            w_action = ACT_PCT;
        end else begin
            w_action = ACT_TEXT;
        end
    end

    // The last result of an item is either its final candidate character or
    // the one that fills the buffer, whichever comes first.
    always_comb begin
        unique case (r_state)
            S_NUM:   w_last = (r_idx == '0) || w_full;
            S_WORD:  w_last = (r_wcnt == WORD_LAST) || w_full;
            S_CHAR:  w_last = 1'b1;
            default: w_last = 1'b0;
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (w_action)
                        ACT_END, ACT_TEXT: n_state = S_CHAR;
                        ACT_DEC:           n_state = S_CONV;
                        ACT_WORD:          n_state = S_WORD;
                        ACT_HEX:           n_state = (w_hex_count == '0) ? S_IDLE : S_NUM;
                        default:           n_state = S_IDLE;
                    endcase
                end
            end
            S_CONV: begin
                if (w_conv.done && !w_conv.busy) begin
                    n_state = (w_dec_count == '0) ? S_IDLE : S_NUM;
                end
            end
            S_NUM, S_WORD, S_CHAR: begin
                if (w_emit && w_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs of the sequencer: handshakes, unit start and the result payload.
    always_comb begin
        i_fmt.ready          = i_rst_n && (r_state == S_IDLE);
        i_cfg.ready          = i_rst_n;
        w_start              = (r_state == S_IDLE) && w_accept && (w_action == ACT_DEC);
        o_res.valid          = 1'b0;
        o_res.out_char       = CH_NUL;
        o_res.last           = w_last;
        o_res.total_length   = '0;
        o_res.bad_specifier  = 1'b0;
        unique case (r_state)
            S_NUM: begin
                o_res.valid    = 1'b1;
                o_res.out_char = glyph(r_digits[r_idx]);
            end
            S_WORD: begin
                o_res.valid    = 1'b1;
                if (r_grp == GROUP_SEP) begin
                    o_res.out_char = CH_USCORE;
                end else begin
                    o_res.out_char = r_word[ARG_W-1] ? CH_ONE : CH_ZERO;
                end
            end
            S_CHAR: begin
                o_res.valid    = 1'b1;
                o_res.out_char = r_char;
                if (r_nul) begin
                    o_res.total_length  = r_total;
                    o_res.bad_specifier = r_bad;
                end
            end
            default: begin
                o_res.valid = 1'b0;
            end
        endcase
    end

    // Datapath next values.
    always_comb begin
        n_phase   = r_phase;
        n_written = r_written;
        n_total   = r_total;
        n_pad     = r_pad;
        n_stopped = r_stopped;
        n_error   = r_error;
        n_nul     = r_nul;
        n_bad     = r_bad;
        n_digits  = r_digits;
        n_idx     = r_idx;
        n_word    = r_word;
        n_grp     = r_grp;
        n_wcnt    = r_wcnt;
        n_char    = r_char;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (w_action)
                        ACT_END: begin
                            // Report the string, then start the next one afresh.
                            n_char    = CH_NUL;
                            n_nul     = 1'b1;
                            n_total   = w_written_inc;
                            n_bad     = r_error;
                            n_phase   = PH_TEXT;
                            n_pad     = 4'd1;
                            n_written = '0;
                            n_stopped = 1'b0;
                            n_error   = 1'b0;
                        end
                        ACT_SKIP: begin
                            n_stopped = 1'b1;
                        end
                        ACT_WIDTH: begin
                            n_pad   = w_ch[3:0];
                            n_phase = PH_WIDTH;
                        end
                        ACT_DEC: begin
                            // Pad width is kept until the digits are counted.
                            n_phase = PH_TEXT;
                        end
                        ACT_HEX: begin
                            n_phase  = PH_TEXT;
                            n_pad    = 4'd1;
                            n_digits = t_digits'({8'h00, w_arg});
                            n_idx    = w_hex_count - IDX_W'(1);
                        end
                        ACT_WORD: begin
                            n_phase = PH_TEXT;
                            n_pad   = 4'd1;
                            n_word  = w_arg;
                            n_grp   = '0;
                            n_wcnt  = '0;
                        end
                        ACT_BAD: begin
                            n_phase   = PH_TEXT;
                            n_pad     = 4'd1;
                            n_stopped = 1'b1;
                            n_error   = 1'b1;
                        end
                        ACT_PCT: begin
                            n_phase = PH_PCT;
                            n_pad   = 4'd1;
                        end
                        ACT_TEXT: begin
                            n_char = w_ch;
                            n_nul  = 1'b0;
                        end
                        default: begin
                            n_phase = r_phase;
                        end
                    endcase
                end
            end
            S_CONV: begin
                if (w_conv.done && !w_conv.busy) begin
                    n_digits = w_bcd;
                    n_idx    = w_dec_count - IDX_W'(1);
                    n_pad    = 4'd1;
                end
            end
            S_NUM, S_WORD, S_CHAR: begin
                if (w_emit && !(r_state == S_CHAR && r_nul)) begin
                    n_written = w_written_inc;
                    if (w_full) begin
                        n_stopped = 1'b1;
                    end
                    if (r_state == S_NUM) begin
                        n_idx = r_idx - IDX_W'(1);
                    end
                    if (r_state == S_WORD) begin
                        n_wcnt = r_wcnt + WCNT_W'(1);
                        if (r_grp == GROUP_SEP) begin
                            n_grp = '0;
                        end else begin
                            n_grp  = r_grp + 4'd1;
                            n_word = {r_word[ARG_W-2:0], 1'b0};
                        end
                    end
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_phase    <= PH_TEXT;
            r_capacity <= CAP_RESET;
            r_written  <= '0;
            r_pad      <= 4'd1;
            r_stopped  <= 1'b0;
            r_error    <= 1'b0;
            r_nul      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_written <= n_written;
            r_pad     <= n_pad;
            r_stopped <= n_stopped;
            r_error   <= n_error;
            r_nul     <= n_nul;
            if (i_cfg.valid && i_cfg.ready) begin
                r_capacity <= i_cfg.capacity;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_total  <= n_total;
        r_bad    <= n_bad;
        r_digits <= n_digits;
        r_idx    <= n_idx;
        r_word   <= n_word;
        r_grp    <= n_grp;
        r_wcnt   <= n_wcnt;
        r_char   <= n_char;
    end

endmodule

`default_nettype wire

FILE: rtl/mpf_checker.sv
// ----------------------------------------------------------------------------
// Mini printf formatter: port checker
// Watches the top level's channels over time and binds to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "mini_printf_formatter_assert.svh"

module mpf_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_ready,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [mpf_pkg::CHAR_W-1:0]  i_out_char,
    input  logic                        i_out_last,
    input  logic [mpf_pkg::CNT_W-1:0]   i_out_total,
    input  logic                        i_out_bad
);
    import mpf_pkg::*;

    logic                               w_res_stall;
    logic                               w_res_nul;
    logic                               w_res_text;
    logic                               w_res_plain;
    logic [CHAR_W+CNT_W+1:0]            w_res_payload;

    assign w_res_stall   = i_out_valid && !i_out_ready;
    assign w_res_nul     = i_out_valid && (i_out_char == CH_NUL);
    assign w_res_text    = i_out_valid && (i_out_char != CH_NUL);
    assign w_res_plain   = (i_out_total == '0) && !i_out_bad;
    assign w_res_payload = {i_out_char, i_out_last, i_out_total, i_out_bad};

    // A stalled result transaction holds its payload.
    `MPF_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, w_res_stall, i_out_valid && $stable(w_res_payload))

    // The terminating NUL always closes its item's run.
    `MPF_ASSERT_IMPL(a_nul_last, i_clk, i_rst_n, w_res_nul, i_out_last)

    // Length and error flag are only reported alongside the NUL.
    `MPF_ASSERT_IMPL(a_status_nul, i_clk, i_rst_n, w_res_text, w_res_plain)

    // One item at a time: no new input is taken while results are pending.
    `MPF_ASSERT_NEVER(a_one_item, i_clk, i_rst_n, i_in_ready && i_out_valid)

endmodule

bind mini_printf_formatter mpf_checker u_mpf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_fmt.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_char  (o_res.out_char),
    .i_out_last  (o_res.last),
    .i_out_total (o_res.total_length),
    .i_out_bad   (o_res.bad_specifier)
);

`default_nettype wire
